[design/hce_pkg.sv]
// Shared constants for the 3D Hilbert index encoder.
package hce_pkg;

    // Field widths fixed by the channel formats
    localparam int COORD_W = 10;
    localparam int INDEX_W = 30;
    localparam int ORDER_W = 4;

    // Curve order after reset
    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd10;

endpackage

[design/hce_if.sv]
// Stream interfaces: coordinate requests in, curve index requests out.
interface hce_coord_if;
    logic                        valid;
    logic                        ready;
    logic [hce_pkg::COORD_W-1:0] coord_x;
    logic [hce_pkg::COORD_W-1:0] coord_y;
    logic [hce_pkg::COORD_W-1:0] coord_z;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    output ready);
endinterface

interface hce_index_if;
    logic                        valid;
    logic                        ready;
    logic [hce_pkg::INDEX_W-1:0] curve_index;

    modport source (output valid, output curve_index, input ready);
    modport sink   (input valid, input curve_index, output ready);
endinterface

[design/hce_plane_stage.sv]
// One bit plane of the rotate and flip pass, with its pipeline register.
module hce_plane_stage #(
    parameter int MAX_BITS = 10,
    parameter int PLANE    = 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [$clog2(MAX_BITS+1)-1:0]        i_eff,
    input  logic                                 i_vld,
    output logic                                 o_rdy,
    input  logic [2:0][MAX_BITS-1:0]             i_w,
    output logic                                 o_vld,
    input  logic                                 i_rdy,
    output logic [2:0][MAX_BITS-1:0]             o_w
);

    localparam logic [MAX_BITS-1:0] BELOW = MAX_BITS'((64'd1 << PLANE) - 64'd1);

    logic                        r_vld;
    logic [2:0][MAX_BITS-1:0]    r_w;
    logic [2:0][MAX_BITS-1:0]    n_w;
    logic                        w_active;
    logic                        w_take;

    // Planes at or above the curve order pass through untouched
    assign w_active = (int'(i_eff) > PLANE);
    assign o_rdy    = !r_vld || i_rdy;
    assign w_take   = i_vld && o_rdy;

    // Rotate and flip against this plane, x then y then z
    always_comb begin
        logic [MAX_BITS-1:0] s;
        s   = '0;
        n_w = i_w;
        if (w_active) begin
            for (int i = 0; i < 3; i++) begin
                if (n_w[i][PLANE]) begin
                    n_w[0] = n_w[0] ^ BELOW;
                end else begin
                    s       = (n_w[0] ^ n_w[i]) & BELOW;
                    n_w[0]  = n_w[0] ^ s;
                    n_w[i]  = n_w[i] ^ s;
                end
            end
        end
    end

    // Hold valid until the next stage takes the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_w <= n_w;
        end
    end

    assign o_vld = r_vld;
    assign o_w   = r_w;

    // Inactive planes leave the words as they came
    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !w_active) |=> (r_w == $past(i_w)))
        else $error("inactive plane changed the words");

    // The plane bit and everything above it are never touched
    a_upper_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (((r_w[0] ^ $past(i_w[0])) & ~BELOW) == '0 &&
                    ((r_w[1] ^ $past(i_w[1])) & ~BELOW) == '0 &&
                    ((r_w[2] ^ $past(i_w[2])) & ~BELOW) == '0))
        else $error("bits at or above the plane were altered");

endmodule

[design/hce_finish.sv]
// Gray coding, correction mask and bit interleave, with the output register.
module hce_finish #(
    parameter int MAX_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vld,
    output logic                            o_rdy,
    input  logic [2:0][MAX_BITS-1:0]        i_w,
    output logic                            o_vld,
    input  logic                            i_rdy,
    output logic [hce_pkg::INDEX_W-1:0]     o_index
);

    localparam int DW = 3 * MAX_BITS;

    logic                              r_vld;
    logic [hce_pkg::INDEX_W-1:0]       r_index;
    logic [hce_pkg::INDEX_W-1:0]       n_index;
    logic                              w_take;

    assign o_rdy  = !r_vld || i_rdy;
    assign w_take = i_vld && o_rdy;

    // Gray code the columns, apply the mask from z, interleave x over y over z
    always_comb begin
        logic [MAX_BITS-1:0]                 g0, g1, g2, t;
        logic [DW-1:0]                       d;
        logic [DW+hce_pkg::INDEX_W-1:0]      ext;
        g0 = i_w[0];
        g1 = i_w[1] ^ g0;
        g2 = i_w[2] ^ g1;
        for (int j = 0; j < MAX_BITS; j++) begin
            t[j] = ^(g2 >> (j + 1));
        end
        g0 = g0 ^ t;
        g1 = g1 ^ t;
        g2 = g2 ^ t;
        for (int p = 0; p < MAX_BITS; p++) begin
            d[3*p+2] = g0[p];
            d[3*p+1] = g1[p];
            d[3*p]   = g2[p];
        end
        ext     = {{hce_pkg::INDEX_W{1'b0}}, d};
        n_index = ext[hce_pkg::INDEX_W-1:0];
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_index <= n_index;
        end
    end

    assign o_vld   = r_vld;
    assign o_index = r_index;

    // A taken request always shows up as a result on the next cycle
    a_take_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> o_vld)
        else $error("accepted request did not reach the output register");

endmodule

[design/hilbert_3d_encode.sv]
// Top level of the pipelined 3D Hilbert curve index encoder.
//
//  channel    direction  payload                          handshake
//  i_coord    in         coord_x, coord_y, coord_z (10b)  valid / ready
//  o_index    out        curve_index (30b)                valid / ready
//  i_cfg_*    in         order_bits (4b)                  write enable
//
//  Throughput: one request per cycle while the sink keeps ready high. The
//  path runs through the input register, one register per rotated plane
//  MAX_BITS-1 down to 1, and the output register. Each stage has its own
//  valid bit and takes a new request when it is empty or its content moves
//  on, so bubbles close up under a stalled sink. Reset is synchronous and
//  clears the valid bits and sets order_bits to 10.
module hilbert_3d_encode #(
    parameter int MAX_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hce_pkg::ORDER_W-1:0]   i_cfg_wdata,
    hce_coord_if.sink                     i_coord,
    hce_index_if.source                   o_index
);

    localparam int EW = $clog2(MAX_BITS + 1);

    logic [hce_pkg::ORDER_W-1:0]   r_order;
    logic [EW-1:0]                 w_eff;
    logic [MAX_BITS-1:0]           w_lowmask;

    logic                          r_vld0;
    logic [2:0][MAX_BITS-1:0]      r_w0;
    logic [2:0][MAX_BITS-1:0]      n_w0;

    logic                          s_vld [MAX_BITS];
    logic                          s_rdy [MAX_BITS];
    logic [2:0][MAX_BITS-1:0]      s_w   [MAX_BITS];

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= hce_pkg::ORDER_RESET;
        end else if (i_cfg_we) begin
            r_order <= i_cfg_wdata;
        end
    end

    // Clamp the order to 1..MAX_BITS
    always_comb begin
        if (int'(r_order) == 0) begin
            w_eff = EW'(1);
        end else if (int'(r_order) > MAX_BITS) begin
            w_eff = EW'(MAX_BITS);
        end else begin
            w_eff = EW'(r_order);
        end
        for (int j = 0; j < MAX_BITS; j++) begin
            w_lowmask[j] = (j < int'(w_eff));
        end
    end

    // Drop coordinate bits at or above the order
    always_comb begin
        logic [MAX_BITS+hce_pkg::COORD_W-1:0] ex, ey, ez;
        ex = {{MAX_BITS{1'b0}}, i_coord.coord_x};
        ey = {{MAX_BITS{1'b0}}, i_coord.coord_y};
        ez = {{MAX_BITS{1'b0}}, i_coord.coord_z};
        n_w0[0] = ex[MAX_BITS-1:0] & w_lowmask;
        n_w0[1] = ey[MAX_BITS-1:0] & w_lowmask;
        n_w0[2] = ez[MAX_BITS-1:0] & w_lowmask;
    end

    // Input stage
    assign i_coord.ready = !r_vld0 || s_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (i_coord.ready) begin
            r_vld0 <= i_coord.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_coord.valid && i_coord.ready) begin
            r_w0 <= n_w0;
        end
    end

    assign s_vld[0] = r_vld0;
    assign s_w[0]   = r_w0;

    // One stage per plane from MAX_BITS-1 down to 1, top plane first
    for (genvar k = 1; k < MAX_BITS; k++) begin : g_plane
        hce_plane_stage #(
            .MAX_BITS (MAX_BITS),
            .PLANE    (MAX_BITS - k)
        ) u_plane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_eff   (w_eff),
            .i_vld   (s_vld[k-1]),
            .o_rdy   (s_rdy[k-1]),
            .i_w     (s_w[k-1]),
            .o_vld   (s_vld[k]),
            .i_rdy   (s_rdy[k]),
            .o_w     (s_w[k])
        );
    end

    // Output stage
    hce_finish #(
        .MAX_BITS (MAX_BITS)
    ) u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_vld[MAX_BITS-1]),
        .o_rdy   (s_rdy[MAX_BITS-1]),
        .i_w     (s_w[MAX_BITS-1]),
        .o_vld   (o_index.valid),
        .i_rdy   (o_index.ready),
        .o_index (o_index.curve_index)
    );

endmodule
